[rtl/core/egcd_pkg.sv]
// Package for the extended GCD block: microcode control word type,
// operation and jump codes, and the microprogram table. No dependencies.
`default_nettype none
package egcd_pkg;

  localparam int STEP_W = 3;

  // Datapath operations.
  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_DIV_INIT = 3'd1;
  localparam logic [2:0] OP_DIV_STEP = 3'd2;
  localparam logic [2:0] OP_UPDATE   = 3'd3;
  localparam logic [2:0] OP_EMIT     = 3'd4;

  // Jump conditions. Without a jump the step counter advances by one.
  localparam logic [2:0] JC_NEXT      = 3'd0;
  localparam logic [2:0] JC_ALWAYS    = 3'd1;
  localparam logic [2:0] JC_NOT_START = 3'd2;
  localparam logic [2:0] JC_RCUR_ZERO = 3'd3;
  localparam logic [2:0] JC_CNT_NZ    = 3'd4;

  // Program step addresses.
  localparam logic [STEP_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] ST_TEST   = 3'd1;
  localparam logic [STEP_W-1:0] ST_DIVIDE = 3'd2;
  localparam logic [STEP_W-1:0] ST_UPDATE = 3'd3;
  localparam logic [STEP_W-1:0] ST_DONE   = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  // The microprogram. Each Euclid step runs TEST, the divide loop and UPDATE.
  function automatic ctl_word_t ucode_rom(input logic [STEP_W-1:0] addr);
    ctl_word_t w;
    case (addr)
      ST_IDLE:   w = '{op: OP_LOAD,     cond: JC_NOT_START, target: ST_IDLE};
      ST_TEST:   w = '{op: OP_DIV_INIT, cond: JC_RCUR_ZERO, target: ST_DONE};
      ST_DIVIDE: w = '{op: OP_DIV_STEP, cond: JC_CNT_NZ,    target: ST_DIVIDE};
      ST_UPDATE: w = '{op: OP_UPDATE,   cond: JC_ALWAYS,    target: ST_TEST};
      ST_DONE:   w = '{op: OP_EMIT,     cond: JC_ALWAYS,    target: ST_IDLE};
      default:   w = '{op: OP_EMIT,     cond: JC_ALWAYS,    target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[rtl/core/extended_gcd_bezout.sv]
// Top level of the extended GCD block: microcoded sequencer and its
// datapath (bit-serial divider, coefficient accumulators). Uses egcd_pkg.
`default_nettype none

// A request is taken when start is high and busy is low. The block then
// runs the iterative Euclid loop and shows gcd(a, b) with Bezout
// coefficients x and y (a*x + b*y = gcd) for exactly one cycle on the out_
// ports, marked by out_strobe; the receiver cannot stall, so it must take
// the result in that cycle. A request with b = 0 returns x = 1, y = 0,
// gcd = a. The run time grows with the number k of Euclid steps (k = 0
// when b = 0, at most about 45 for 31 bit operands). It is set by the
// one shared restoring divider, which retires one quotient bit per
// cycle, so each quotient needs a full divide loop plus one setup and
// one update step. busy falls in the cycle the strobe is shown, so a
// new request may be taken then. One request is handled at a time.
module extended_gcd_bezout #(
  parameter int WORD_BITS = 31
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire        [WORD_BITS-1:0]  in_first_value,
  input  wire        [WORD_BITS-1:0]  in_second_value,
  output logic                        out_strobe,
  output logic signed [WORD_BITS:0]   out_coef_first,
  output logic signed [WORD_BITS:0]   out_coef_second,
  output logic       [WORD_BITS-1:0]  out_divisor
);

  import egcd_pkg::*;

  localparam int CNT_W = $clog2(WORD_BITS);
  localparam int CW    = WORD_BITS + 1;   // coefficient width

  // Sequencer state.
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              strobe_r, strobe_nxt;
  ctl_word_t         ctl;
  logic              take_jump;

  // Remainder pair and coefficient pairs. Coefficients are kept modulo
  // 2^CW; the final values always fit, so the wrap in between is harmless.
  logic [WORD_BITS-1:0] r_prev_r, r_cur_r;
  logic [CW-1:0]        s_prev_r, s_cur_r, t_prev_r, t_cur_r;

  // Divider state: dividend shift register, partial remainder, bit count,
  // and the running products q*s_cur and q*t_cur built from quotient bits.
  logic [WORD_BITS-1:0] dvd_r, rem_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CW-1:0]        sacc_r, tacc_r;

  logic [WORD_BITS:0]   trial;
  logic                 q_bit;
  logic [WORD_BITS:0]   trial_diff;
  logic [WORD_BITS-1:0] rem_step;
  logic [CW-1:0]        sacc_step, tacc_step;
  logic                 accept;

  assign ctl    = ucode_rom(step_r);
  assign busy   = (step_r != ST_IDLE);
  assign accept = start && (step_r == ST_IDLE);

  // Jump decision from the control word's condition field.
  always_comb begin
    case (ctl.cond)
      JC_NEXT:      take_jump = 1'b0;
      JC_ALWAYS:    take_jump = 1'b1;
      JC_NOT_START: take_jump = !start;
      JC_RCUR_ZERO: take_jump = (r_cur_r == '0);
      JC_CNT_NZ:    take_jump = (cnt_r != '0);
      default:      take_jump = 1'b1;
    endcase
    step_nxt   = take_jump ? ctl.target : step_r + STEP_W'(1);
    strobe_nxt = (ctl.op == OP_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // One restoring division step: shift in the next dividend bit and
  // subtract the divisor when it fits.
  always_comb begin
    trial      = {rem_r, dvd_r[WORD_BITS-1]};
    q_bit      = (trial >= {1'b0, r_cur_r});
    trial_diff = trial - {1'b0, r_cur_r};
    rem_step   = q_bit ? trial_diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
    sacc_step  = {sacc_r[CW-2:0], 1'b0} + (q_bit ? s_cur_r : '0);
    tacc_step  = {tacc_r[CW-2:0], 1'b0} + (q_bit ? t_cur_r : '0);
  end

  // Datapath, driven by the op field of the current control word.
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        if (accept) begin
          r_prev_r <= in_first_value;
          r_cur_r  <= in_second_value;
          s_prev_r <= CW'(1);
          s_cur_r  <= '0;
          t_prev_r <= '0;
          t_cur_r  <= CW'(1);
        end
      end
      OP_DIV_INIT: begin
        dvd_r  <= r_prev_r;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(WORD_BITS - 1);
        sacc_r <= '0;
        tacc_r <= '0;
      end
      OP_DIV_STEP: begin
        dvd_r  <= {dvd_r[WORD_BITS-2:0], 1'b0};
        rem_r  <= rem_step;
        cnt_r  <= cnt_r - CNT_W'(1);
        sacc_r <= sacc_step;
        tacc_r <= tacc_step;
      end
      OP_UPDATE: begin
        // rem_r now holds r_prev mod r_cur, the accumulators q*s and q*t.
        r_prev_r <= r_cur_r;
        r_cur_r  <= rem_r;
        s_prev_r <= s_cur_r;
        s_cur_r  <= s_prev_r - sacc_r;
        t_prev_r <= t_cur_r;
        t_cur_r  <= t_prev_r - tacc_r;
      end
      OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // The result registers hold still through the strobe cycle; the next
  // load can only change them at the edge that ends it.
  assign out_strobe      = strobe_r;
  assign out_coef_first  = s_prev_r;
  assign out_coef_second = t_prev_r;
  assign out_divisor     = r_prev_r;

endmodule
`default_nettype wire
